/* hw/rtl/tng_pkg.sv */
// Package for the tone and noise generator: shared constants, register
// indexes and the configuration bundle. No dependencies.

package tng_pkg;

   // Defaults of the top-level parameters.
   localparam int MAX_CHANNELS_DEF    = 8;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF     = 16;

   // Register file geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Fixed field widths.
   localparam int AMP_W       = 15;
   localparam int AMP_FRAC    = 15;
   localparam int CH_COUNT_W  = 4;
   localparam int CHANNEL_W   = 3;
   localparam int PHASE_W     = 32;
   localparam int NOISE_W     = 32;

   // Register reset values.
   localparam logic             NOISE_MODE_RST    = 1'b0;
   localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd39370534;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 15'd6554;
   localparam logic [CH_COUNT_W-1:0] CH_COUNT_RST = 4'd2;
   localparam logic [NOISE_W-1:0] NOISE_SEED_RST  = 32'd1;

   typedef enum logic [2:0] {
      CSR_NOISE_MODE    = 3'd0,
      CSR_PHASE_STEP    = 3'd1,
      CSR_AMPLITUDE     = 3'd2,
      CSR_CHANNEL_COUNT = 3'd3,
      CSR_NOISE_SEED    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                  noise_mode;
      logic [PHASE_W-1:0]    phase_step;
      logic [AMP_W-1:0]      amplitude;
      logic [CH_COUNT_W-1:0] channel_count;
      logic [NOISE_W-1:0]    noise_seed;
      logic                  seed_load;
   } cfg_type;

endpackage

/* hw/rtl/tng_csr.sv */
// Configuration registers of the tone and noise generator behind an
// APB-style port. Depends on tng_pkg.

module tng_csr
   import tng_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic                  mode_ff,  mode_in;
   logic [PHASE_W-1:0]    step_ff,  step_in;
   logic [AMP_W-1:0]      amp_ff,   amp_in;
   logic [CH_COUNT_W-1:0] count_ff, count_in;
   logic [NOISE_W-1:0]    seed_ff,  seed_in;
   logic                  load_in;
   logic                  wr_en;
   csr_index_type         index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      mode_in  = mode_ff;
      step_in  = step_ff;
      amp_in   = amp_ff;
      count_in = count_ff;
      seed_in  = seed_ff;
      load_in  = 1'b0;
      if (wr_en) begin
         unique case (index)
            CSR_NOISE_MODE:    mode_in  = pwdata[0];
            CSR_PHASE_STEP:    step_in  = pwdata[PHASE_W-1:0];
            CSR_AMPLITUDE:     amp_in   = pwdata[AMP_W-1:0];
            CSR_CHANNEL_COUNT: count_in = pwdata[CH_COUNT_W-1:0];
            CSR_NOISE_SEED: begin
               seed_in = pwdata[NOISE_W-1:0];
               load_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= NOISE_MODE_RST;
         step_ff  <= PHASE_STEP_RST;
         amp_ff   <= AMPLITUDE_RST;
         count_ff <= CH_COUNT_RST;
         seed_ff  <= NOISE_SEED_RST;
      end else begin
         mode_ff  <= mode_in;
         step_ff  <= step_in;
         amp_ff   <= amp_in;
         count_ff <= count_in;
         seed_ff  <= seed_in;
      end
   end

   always_comb begin
      unique case (index)
         CSR_NOISE_MODE:    prdata = CSR_DATA_W'(mode_ff);
         CSR_PHASE_STEP:    prdata = CSR_DATA_W'(step_ff);
         CSR_AMPLITUDE:     prdata = CSR_DATA_W'(amp_ff);
         CSR_CHANNEL_COUNT: prdata = CSR_DATA_W'(count_ff);
         CSR_NOISE_SEED:    prdata = CSR_DATA_W'(seed_ff);
         default:           prdata = '0;
      endcase
   end

   // The noise register reloads at the same edge that writes the seed, so a
   // transaction accepted right after the write already sees the new seed.
   assign cfg.noise_mode    = mode_ff;
   assign cfg.phase_step    = step_ff;
   assign cfg.amplitude     = amp_ff;
   assign cfg.channel_count = count_ff;
   assign cfg.noise_seed    = seed_in;
   assign cfg.seed_load     = load_in;

endmodule

/* hw/rtl/tng_sine_rom.sv */
// Sine lookup ROM with a registered read port. The table is computed at
// elaboration from a Taylor series in Q30. Depends on tng_pkg.

module tng_sine_rom
   import tng_pkg::*;
#(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [SINE_TABLE_BITS-1:0]    rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);

   localparam int TABLE_SIZE   = 1 << SINE_TABLE_BITS;
   localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;
   localparam longint FULL_SCALE  = (64'd1 << (SAMPLE_BITS - 1)) - 1;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [SAMPLE_BITS-1:0] rom_type [TABLE_SIZE];

   // Unsigned 64-bit quotient by shift and subtract. It is only evaluated
   // while the table is built, never in hardware.
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      int          b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sine of k quarter steps of pi/2, scaled to full scale.
   function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input logic [63:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      int          n;
      x    = (k * HALF_PI_Q30) >> QUARTER_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n < 13; n += 2) begin
         term = udiv64((term * x2) >> 30, 64'((n + 1) * (n + 2)));
         if ((((n + 1) >> 1) & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (v > 64'(FULL_SCALE)) begin
         v = 64'(FULL_SCALE);
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type                t;
      int                     i;
      int                     quad;
      int                     r;
      logic [63:0]            k;
      logic [SAMPLE_BITS-1:0] s;
      for (i = 0; i < TABLE_SIZE; i++) begin
         quad = i >> QUARTER_BITS;
         r    = i & (QUARTER - 1);
         k    = ((quad & 1) == 1) ? 64'(QUARTER - r) : 64'(r);
         s    = quarter_sine(k);
         t[i] = ((quad & 2) == 2) ? -s : s;
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic signed [SAMPLE_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

/* hw/rtl/tng_sample_pipe.sv */
// Frame sample pipeline: phase accumulator, xorshift noise register, ROM
// lookup stage and amplitude scaling stage. Depends on tng_pkg, tng_sine_rom.

module tng_sample_pipe
   import tng_pkg::*;
#(
   parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int CNT_W           = $clog2(MAX_CHANNELS + 1)
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_frame_tick,
   output logic                          frame_valid,
   input  logic                          frame_ready,
   output logic signed [SAMPLE_BITS-1:0] frame_sample,
   output logic [CNT_W-1:0]              frame_count
);

   localparam logic [NOISE_W-1:0] NOISE_RST =
      (NOISE_SEED_RST == '0) ? NOISE_W'(1) : NOISE_SEED_RST;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [NOISE_W-1:0] noise_ff, noise_in;
   logic [NOISE_W-1:0] noise_next;
   logic [NOISE_W-1:0] ns_a;
   logic [NOISE_W-1:0] ns_b;

   logic                          a_vld_ff, a_vld_in;
   logic                          a_mode_ff;
   logic signed [SAMPLE_BITS-1:0] a_noise_ff;
   logic [CNT_W-1:0]              a_count_ff;
   logic signed [SAMPLE_BITS-1:0] rom_data;
   logic signed [SAMPLE_BITS-1:0] a_value;

   logic                          b_vld_ff, b_vld_in;
   logic signed [SAMPLE_BITS-1:0] b_sample_ff;
   logic [CNT_W-1:0]              b_count_ff;
   logic signed [SAMPLE_BITS+15:0] product;

   logic             a_free;
   logic             b_free;
   logic             start;
   logic [CNT_W-1:0] count_in;

   assign b_free    = !b_vld_ff || frame_ready;
   assign a_free    = !a_vld_ff || b_free;
   assign req_ready = a_free;
   assign start     = req_valid && req_ready && req_frame_tick;

   // Xorshift32 with shifts 13, 17 and 5.
   assign ns_a       = noise_ff ^ (noise_ff << 13);
   assign ns_b       = ns_a ^ (ns_a >> 17);
   assign noise_next = ns_b ^ (ns_b << 5);

   always_comb begin
      if (cfg.channel_count == '0) begin
         count_in = CNT_W'(1);
      end else if (cfg.channel_count > CH_COUNT_W'(MAX_CHANNELS)) begin
         count_in = CNT_W'(MAX_CHANNELS);
      end else begin
         count_in = CNT_W'(cfg.channel_count);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      noise_in = noise_ff;
      if (start && !cfg.noise_mode) begin
         phase_in = phase_ff + cfg.phase_step;
      end
      if (cfg.seed_load) begin
         noise_in = (cfg.noise_seed == '0) ? NOISE_W'(1) : cfg.noise_seed;
      end else if (start && cfg.noise_mode) begin
         noise_in = noise_next;
      end
   end

   tng_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (start),
      .rd_addr (phase_ff[PHASE_W-1 -: SINE_TABLE_BITS]),
      .rd_data (rom_data)
   );

   assign a_vld_in = a_free ? start : a_vld_ff;
   assign b_vld_in = b_free ? a_vld_ff : b_vld_ff;

   assign a_value = a_mode_ff ? a_noise_ff : rom_data;
   assign product = a_value * $signed({1'b0, cfg.amplitude});

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         noise_ff <= NOISE_RST;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         noise_ff <= noise_in;
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   // Noise sample is the new top bits with the sign bit flipped.
   always_ff @(posedge clock) begin
      if (start) begin
         a_mode_ff  <= cfg.noise_mode;
         a_noise_ff <= {~noise_next[NOISE_W-1], noise_next[NOISE_W-2 -: SAMPLE_BITS-1]};
         a_count_ff <= count_in;
      end
      if (a_vld_ff && b_free) begin
         b_sample_ff <= product[SAMPLE_BITS+AMP_FRAC-1:AMP_FRAC];
         b_count_ff  <= a_count_ff;
      end
   end

   assign frame_valid  = b_vld_ff;
   assign frame_sample = b_sample_ff;
   assign frame_count  = b_count_ff;

endmodule

/* hw/rtl/tng_chan_seq.sv */
// Output sequencer: repeats one frame sample on each channel of the frame
// and flags the last channel. Depends on tng_pkg.

module tng_chan_seq
   import tng_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int CNT_W        = $clog2(MAX_CHANNELS + 1)
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          frame_valid,
   output logic                          frame_ready,
   input  logic signed [SAMPLE_BITS-1:0] frame_sample,
   input  logic [CNT_W-1:0]              frame_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic [CHANNEL_W-1:0]          rsp_channel,
   output logic                          rsp_last_channel
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic                          vld_ff, vld_in;
   logic [CH_W-1:0]               chan_ff, chan_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [CNT_W-1:0]              count_ff;
   logic                          last;
   logic                          load;

   assign last        = (CNT_W'(chan_ff) + CNT_W'(1)) == count_ff;
   assign frame_ready = !vld_ff || (rsp_ready && last);
   assign load        = frame_valid && frame_ready;

   always_comb begin
      vld_in  = vld_ff;
      chan_in = chan_ff;
      if (vld_ff && rsp_ready) begin
         if (last) begin
            vld_in = 1'b0;
         end else begin
            chan_in = chan_ff + CH_W'(1);
         end
      end
      if (load) begin
         vld_in  = 1'b1;
         chan_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         chan_ff <= '0;
      end else begin
         vld_ff  <= vld_in;
         chan_ff <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= frame_sample;
         count_ff  <= frame_count;
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_sample       = sample_ff;
   assign rsp_channel      = CHANNEL_W'(chan_ff);
   assign rsp_last_channel = last;

endmodule

/* hw/rtl/tone_noise_generator.sv */
// Tone and noise generator top level: configuration registers, frame sample
// pipeline and channel sequencer. Depends on tng_pkg and the tng_ modules.
//
// Every frame_tick transaction with the tick bit set produces one audio frame:
// a single sample, repeated once per channel with the channel index and a
// last-channel flag, so a frame yields channel_count response transactions
// (a count of zero acts as one, and counts above MAX_CHANNELS saturate). In
// tone mode the sample is a lookup of a 2^SINE_TABLE_BITS-entry sine ROM at
// the top bits of a 32-bit phase accumulator, which then advances by
// phase_step; in noise mode a xorshift32 register steps and its top bits,
// sign bit flipped, give the sample. The sample is scaled by the Q0.15
// amplitude with a floor (arithmetic) shift. A tick transaction with the bit
// clear is consumed and produces nothing. A request passes a ROM read stage
// and a scaling stage before reaching the output register. The output register
// sends one response per cycle while rsp_ready is high, and new requests are
// accepted while earlier frames are still in flight. Writing noise_seed
// reloads the noise register at the same edge (a zero seed loads one).
// Registers lie at byte addresses 0, 4, 8, 12 and 16 (noise_mode, phase_step,
// amplitude, channel_count, noise_seed) and should only be written while the
// block is idle.

module tone_noise_generator
   import tng_pkg::*;
#(
   parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_frame_tick,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic [CHANNEL_W-1:0]          rsp_channel,
   output logic                          rsp_last_channel,
   // Register port.
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   // Width of a channel count, able to hold MAX_CHANNELS itself.
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   cfg_type                       cfg;
   logic                          frame_valid;
   logic                          frame_ready;
   logic signed [SAMPLE_BITS-1:0] frame_sample;
   logic [CNT_W-1:0]              frame_count;

   tng_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The pipeline holds the generator state and produces one scaled
   // sample per frame.
   tng_sample_pipe #(
      .MAX_CHANNELS    (MAX_CHANNELS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .CNT_W           (CNT_W)
   ) u_pipe (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_tick (req_frame_tick),
      .frame_valid    (frame_valid),
      .frame_ready    (frame_ready),
      .frame_sample   (frame_sample),
      .frame_count    (frame_count)
   );

   // The sequencer fans the frame sample out across the channels.
   tng_chan_seq #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .CNT_W        (CNT_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .frame_valid      (frame_valid),
      .frame_ready      (frame_ready),
      .frame_sample     (frame_sample),
      .frame_count      (frame_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_last_channel (rsp_last_channel)
   );

endmodule

/* dv/tng_frame_checker.sv */
// Frame checker for the tone and noise generator: watches the request, response
// and register ports, predicts every response and compares it field by field.
// Depends on tng_pkg.

module tng_frame_checker
   import tng_pkg::*;
#(
   parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_frame_tick,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  logic [CHANNEL_W-1:0]          rsp_channel,
   input  logic                          rsp_last_channel,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   input  logic                          pready,
   output int unsigned                   fail_count,
   output int unsigned                   outstanding,
   output int unsigned                   results_seen
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROM_DEPTH  = 1 << SINE_TABLE_BITS;
   localparam int FULL_SCALE = (1 << (SAMPLE_BITS - 1)) - 1;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHANNEL_W-1:0]          channel;
      logic                          last_channel;
   } channel_sample_type;

   logic signed [SAMPLE_BITS-1:0] sine_rom [ROM_DEPTH];

   logic                  mode_noise;
   logic [PHASE_W-1:0]    step_reg;
   logic [AMP_W-1:0]      gain_reg;
   logic [CH_COUNT_W-1:0] count_reg;
   logic [NOISE_W-1:0]    seed_reg;
   logic [PHASE_W-1:0]    phase;
   logic [NOISE_W-1:0]    lfsr;

   channel_sample_type sample_queue [$];

   // One quarter-wave point from a Q30 Taylor series of sin(k * pi/2 / Q).
   function automatic int quarter_sine(input longint unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      int              n;
      x    = (k * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n < 13; n += 2) begin
         term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
         if ((((n + 1) / 2) % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = longint'(sum);
      v = (v * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) begin
         v = FULL_SCALE;
      end
      return int'(v);
   endfunction

   initial begin : build_rom
      int i;
      int quad;
      int r;
      int s;
      int q;
      q = 1 << (SINE_TABLE_BITS - 2);
      for (i = 0; i < ROM_DEPTH; i++) begin
         quad = i / q;
         r    = i % q;
         s    = quarter_sine((quad % 2 == 1) ? (q - r) : r);
         sine_rom[i] = SAMPLE_BITS'((quad >= 2) ? -s : s);
      end
   end

   task automatic write_register(input logic [2:0] index, input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_NOISE_MODE:    mode_noise = data[0];
         CSR_PHASE_STEP:    step_reg   = data[PHASE_W-1:0];
         CSR_AMPLITUDE:     gain_reg   = data[AMP_W-1:0];
         CSR_CHANNEL_COUNT: count_reg  = data[CH_COUNT_W-1:0];
         CSR_NOISE_SEED: begin
            seed_reg = data[NOISE_W-1:0];
            lfsr     = (seed_reg == 0) ? 1 : seed_reg;
         end
         default: ;
      endcase
   endtask

   // Advances the active generator once and queues the frame's per-channel samples.
   task automatic synthesize_frame();
      logic [NOISE_W-1:0]            x;
      logic signed [SAMPLE_BITS-1:0] raw;
      longint                        product;
      channel_sample_type            entry;
      int                            count;
      int                            c;
      if (mode_noise) begin
         x    = lfsr;
         x    = x ^ (x << 13);
         x    = x ^ (x >> 17);
         x    = x ^ (x << 5);
         lfsr = x;
         raw  = {~x[NOISE_W-1], x[NOISE_W-2 -: SAMPLE_BITS-1]};
      end else begin
         raw   = sine_rom[phase[PHASE_W-1 -: SINE_TABLE_BITS]];
         phase = phase + step_reg;
      end
      product = longint'(raw) * longint'(gain_reg);
      count   = (count_reg == 0) ? 1 : ((count_reg > MAX_CHANNELS) ? MAX_CHANNELS : count_reg);
      entry.sample = SAMPLE_BITS'(product >>> AMP_FRAC);
      for (c = 0; c < count; c++) begin
         entry.channel      = CHANNEL_W'(c);
         entry.last_channel = (c == count - 1);
         sample_queue.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      channel_sample_type want;
      if (reset) begin
         mode_noise = NOISE_MODE_RST;
         step_reg   = PHASE_STEP_RST;
         gain_reg   = AMPLITUDE_RST;
         count_reg  = CH_COUNT_RST;
         seed_reg   = NOISE_SEED_RST;
         lfsr       = (NOISE_SEED_RST == 0) ? 1 : NOISE_SEED_RST;
         phase      = 0;
         sample_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (sample_queue.size() == 0) begin
               $error("response transaction with nothing pending: sample %0d channel %0d",
                      rsp_sample, rsp_channel);
               fail_count++;
            end else begin
               want = sample_queue.pop_front();
               if (rsp_sample !== want.sample) begin
                  $error("sample mismatch: expected %0d, actual %0d", want.sample, rsp_sample);
                  fail_count++;
               end
               if (rsp_channel !== want.channel) begin
                  $error("channel mismatch: expected %0d, actual %0d",
                         want.channel, rsp_channel);
                  fail_count++;
               end
               if (rsp_last_channel !== want.last_channel) begin
                  $error("last_channel mismatch: expected %0d, actual %0d",
                         want.last_channel, rsp_last_channel);
                  fail_count++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            write_register(paddr[CSR_ADDR_W-1:2], pwdata);
         end
         if (req_valid && req_ready && req_frame_tick) begin
            synthesize_frame();
         end
      end
      outstanding = sample_queue.size();
   end

endmodule

/* dv/tb_top.sv */
// Top of the tone and noise generator testbench: clock, reset, request and
// register stimulus, response back-pressure and the final verdict.
// Depends on tng_pkg, tone_noise_generator and tng_frame_checker.

module tb_top
   import tng_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // The drain after the last sample returns is ample for a tick transaction
   // that carries no frame to clear the pipeline.
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 100;

   // Register indexes past the last register; writes to them must be ignored.
   localparam logic [2:0] UNMAPPED_INDEX_LOW  = 3'd5;
   localparam logic [2:0] UNMAPPED_INDEX_HIGH = 3'd7;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_frame_tick;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [SAMPLE_BITS_DEF-1:0] rsp_sample;
   logic [CHANNEL_W-1:0]        rsp_channel;
   logic                        rsp_last_channel;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [CSR_ADDR_W-1:0]       paddr;
   logic [CSR_DATA_W-1:0]       pwdata;
   logic [CSR_DATA_W-1:0]       prdata;
   logic                        pready;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned results_seen;

   // When set, neither side inserts idle cycles, so the block runs at full rate.
   bit          no_gaps;
   int unsigned ticks_sent;
   int unsigned empty_ticks;
   int unsigned csr_writes;
   int unsigned settings_used;
   int unsigned cycle_count;

   tone_noise_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_tick   (req_frame_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_last_channel (rsp_last_channel),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   tng_frame_checker frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_tick   (req_frame_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_last_channel (rsp_last_channel),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .results_seen     (results_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The cycle counter is the watchdog: a hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped by the cycle limit with %0d samples outstanding.", outstanding);
      $display("status: fail");
      $finish;
   end

   // Sends one tick transaction after a random gap. Valid stays high from the
   // gap's end until the transaction is accepted, and the task returns on the
   // following falling edge with valid still high, so that back-to-back
   // transactions need no second assignment within one time step.
   task automatic drive_tick(input logic tick);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_tick <= tick;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      ticks_sent++;
      if (!tick) begin
         empty_ticks++;
      end
   endtask

   // Lowers the request valid and waits until every predicted sample has come
   // back, then lets the pipeline drain in case the last tick carried no frame.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register write: a setup phase, an access phase, and an idle gap after
   // it so that a following write does not reassign psel in the same step.
   task automatic write_csr(input logic [2:0] index, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      csr_writes++;
   endtask

   // Picks a random register setting, leaning toward the extremes of each field.
   task automatic apply_random_setting();
      logic [CSR_DATA_W-1:0] step;
      logic [CSR_DATA_W-1:0] gain;
      logic [CSR_DATA_W-1:0] count;
      case ($urandom_range(0, 3))
         0:       step = 32'h0000_0000;
         1:       step = 32'h8000_0000;
         2:       step = $urandom;
         default: step = $urandom_range(32'h0010_0000, 32'h0400_0000);
      endcase
      case ($urandom_range(0, 3))
         0:       gain = 32'h0000_0000;
         1:       gain = 32'h0000_7FFF;
         default: gain = $urandom;
      endcase
      count = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, MAX_CHANNELS_DEF);
      write_csr(CSR_NOISE_MODE, $urandom);
      write_csr(CSR_PHASE_STEP, step);
      write_csr(CSR_AMPLITUDE, gain);
      write_csr(CSR_CHANNEL_COUNT, count);
      // A seed write restarts the noise sequence, so it is left out at times to
      // let the sequence run on across settings.
      if ($urandom_range(0, 1) == 1) begin
         write_csr(CSR_NOISE_SEED, ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
      end
      settings_used++;
   endtask

   // The receiver draws a random stall, or none when no_gaps is set, before each
   // response transaction and then holds ready high until one is accepted.
   initial begin : response_sink
      int unsigned stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int phase_index;
      int item;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_frame_tick = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      no_gaps        = 1'b0;
      ticks_sent     = 0;
      empty_ticks    = 0;
      csr_writes     = 0;
      settings_used  = 1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: stereo tone at the default pitch and gain. A tick
      // transaction with the bit clear must pass through without a frame.
      drive_tick(1'b1);
      drive_tick(1'b1);
      drive_tick(1'b0);
      drive_tick(1'b1);
      drive_tick(1'b1);

      // A quarter-turn step at full gain visits four points a quarter turn apart
      // in the sine table, on all eight channels.
      wait_idle();
      write_csr(CSR_AMPLITUDE, 32'h0000_7FFF);
      write_csr(CSR_PHASE_STEP, 32'h4000_0000);
      write_csr(CSR_CHANNEL_COUNT, MAX_CHANNELS_DEF);
      settings_used++;
      repeat (4) drive_tick(1'b1);

      // Half-turn step, and a channel count of zero that acts as one.
      wait_idle();
      write_csr(CSR_PHASE_STEP, 32'h8000_0000);
      write_csr(CSR_CHANNEL_COUNT, 32'h0);
      settings_used++;
      repeat (2) drive_tick(1'b1);

      // A step above half a turn still wraps, zero gain silences the output,
      // and a count above the channel limit saturates.
      wait_idle();
      write_csr(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      write_csr(CSR_AMPLITUDE, 32'h0);
      write_csr(CSR_CHANNEL_COUNT, 32'hF);
      settings_used++;
      repeat (2) drive_tick(1'b1);

      // Noise at full gain from a zero seed, which must load as one.
      wait_idle();
      write_csr(CSR_NOISE_MODE, 32'h1);
      write_csr(CSR_NOISE_SEED, 32'h0);
      write_csr(CSR_AMPLITUDE, 32'h0000_7FFF);
      write_csr(CSR_CHANNEL_COUNT, 32'h1);
      settings_used++;
      repeat (3) drive_tick(1'b1);

      // All-ones seed; gain written with bits above its width, count above the limit.
      wait_idle();
      write_csr(CSR_NOISE_SEED, 32'hFFFF_FFFF);
      write_csr(CSR_AMPLITUDE, 32'hFFFF_FFFF);
      write_csr(CSR_CHANNEL_COUNT, 32'h9);
      settings_used++;
      drive_tick(1'b1);
      drive_tick(1'b0);
      drive_tick(1'b1);
      drive_tick(1'b1);

      // Writes past the last register must change nothing; the mode write
      // sets every bit but the low one, which is clear, returning to tone.
      wait_idle();
      write_csr(UNMAPPED_INDEX_LOW, $urandom);
      write_csr(UNMAPPED_INDEX_HIGH, $urandom);
      write_csr(CSR_NOISE_MODE, 32'hFFFF_FFFE);
      settings_used++;
      repeat (2) drive_tick(1'b1);

      // Random phases, each under a fresh setting. One phase runs with no idle
      // cycles on either side, and one pauses the sender midway until every
      // predicted sample has been returned.
      for (phase_index = 0; phase_index < RANDOM_PHASES; phase_index++) begin
         wait_idle();
         apply_random_setting();
         no_gaps = (phase_index == 2);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if (phase_index == 1 && item == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               @(negedge clock);
               while (outstanding != 0) @(negedge clock);
            end
            drive_tick($urandom_range(0, 9) != 0);
         end
         no_gaps = 1'b0;
      end

      wait_idle();
      $display("Sent %0d tick transactions (%0d with the tick clear) under %0d settings.",
               ticks_sent, empty_ticks, settings_used);
      $display("Made %0d register writes and checked %0d response transactions.",
               csr_writes, results_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* tone_noise_generator.f */
hw/rtl/tng_pkg.sv
hw/rtl/tng_csr.sv
hw/rtl/tng_sine_rom.sv
hw/rtl/tng_sample_pipe.sv
hw/rtl/tng_chan_seq.sv
hw/rtl/tone_noise_generator.sv
dv/tng_frame_checker.sv
dv/tb_top.sv
